[rtl/rc4_pkg.sv]
`default_nettype none

package rc4_pkg;

  // Key byte count: holds 0 up to 256 stored bytes
  localparam int unsigned CNT_W = 9;

  // Default key store depth in bytes (1 to 256)
  localparam int unsigned KEY_BYTES_DEF = 256;

  // Input kinds carried on tuser
  localparam logic MODE_KEY  = 1'b0;
  localparam logic MODE_DATA = 1'b1;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_INIT,   // write identity permutation, one entry a cycle
    ST_IDLE,   // ready for a word
    ST_D_J,    // data: take S[i], form j, read S[j]
    ST_D_WI,   // data: take S[j], write S[i]
    ST_D_WJ,   // data: write S[j], read S[S[i]+S[j]]
    ST_D_KS,   // data: form keystream byte, load output
    ST_K_RD,   // schedule: read S[n] and key byte
    ST_K_J,    // schedule: form j, read S[j]
    ST_K_WI,   // schedule: write S[n]
    ST_K_WJ    // schedule: write S[j], advance n
  } state_t;

endpackage

`default_nettype wire

[rtl/rc4_stream_cipher.sv]
`default_nettype none
// A data word steps through the S[j] read, the two swap writes and the keystream read
// before its result is registered; the engine takes no new word before that result is loaded,
// a pace set by the single read and write ports of the permutation memory (3 reads, 2 writes per word).
// A stalled result holds the engine in its last step. A key word without the last flag
// leaves in_tready high; the last key word holds in_tready low through 256 identity writes
// and 256 schedule steps. Reset: synchronous, active low; 256 identity writes follow.

module rc4_stream_cipher #(
  parameter int unsigned KEY_BYTES = rc4_pkg::KEY_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // input stream
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] value
  input  wire logic       in_tuser,   // [0] mode
  input  wire logic       in_tlast,   // last_flag
  // result stream
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata   // [7:0] cipher_byte
);

  localparam int unsigned CW = rc4_pkg::CNT_W;

  rc4_pkg::state_t state_r, state_nxt;

  // Permutation and key memories
  logic [7:0] perm_mem [256];
  logic [7:0] key_mem  [256];
  logic [7:0] perm_rdata_r;
  logic [7:0] key_rdata_r;
  logic       perm_we;
  logic [7:0] perm_waddr, perm_wdata, perm_raddr;
  logic       key_we;

  // Datapath registers
  logic [7:0]    i_r, i_nxt;
  logic [7:0]    j_r, j_nxt;
  logic [7:0]    si_r, si_nxt;
  logic [7:0]    sj_r, sj_nxt;
  logic [7:0]    kpos_r, kpos_nxt;
  logic [CW-1:0] key_count_r, key_count_nxt;
  logic [7:0]    value_r, value_nxt;
  logic          hit_r, hit_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_data_r, out_data_nxt;

  logic          accept;
  logic          key_room;
  logic          out_free;
  logic [7:0]    j_sum;
  logic [7:0]    ks_addr;
  logic [7:0]    ks_byte;
  logic [CW-1:0] kpos_inc;

  assign accept    = in_tvalid && in_tready;
  assign key_room  = key_count_r < CW'(KEY_BYTES);
  assign out_free  = !out_valid_r || out_tready;
  assign ks_addr   = si_r + sj_r;
  assign ks_byte   = hit_r ? si_r : perm_rdata_r;
  assign kpos_inc  = {1'b0, kpos_r} + CW'(1);

  // Shared index adder: j plus S entry plus key byte (key term only in the schedule)
  assign j_sum = j_r + perm_rdata_r + ((state_r == rc4_pkg::ST_K_J) ? key_rdata_r : 8'd0);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rc4_pkg::ST_INIT: begin
        // after reset go idle; after a last key word the key store is never empty
        if (i_r == 8'hFF) begin
          state_nxt = (key_count_r != '0) ? rc4_pkg::ST_K_RD : rc4_pkg::ST_IDLE;
        end
      end
      rc4_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_tuser == rc4_pkg::MODE_DATA) begin
            state_nxt = rc4_pkg::ST_D_J;
          end else if (in_tlast) begin
            state_nxt = rc4_pkg::ST_INIT;
          end
        end
      end
      rc4_pkg::ST_D_J:  state_nxt = rc4_pkg::ST_D_WI;
      rc4_pkg::ST_D_WI: state_nxt = rc4_pkg::ST_D_WJ;
      rc4_pkg::ST_D_WJ: state_nxt = rc4_pkg::ST_D_KS;
      rc4_pkg::ST_D_KS: begin
        if (out_free) state_nxt = rc4_pkg::ST_IDLE;
      end
      rc4_pkg::ST_K_RD: state_nxt = rc4_pkg::ST_K_J;
      rc4_pkg::ST_K_J:  state_nxt = rc4_pkg::ST_K_WI;
      rc4_pkg::ST_K_WI: state_nxt = rc4_pkg::ST_K_WJ;
      rc4_pkg::ST_K_WJ: begin
        state_nxt = (i_r == 8'hFF) ? rc4_pkg::ST_IDLE : rc4_pkg::ST_K_RD;
      end
      default: state_nxt = rc4_pkg::ST_INIT;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    in_tready     = 1'b0;
    i_nxt         = i_r;
    j_nxt         = j_r;
    si_nxt        = si_r;
    sj_nxt        = sj_r;
    kpos_nxt      = kpos_r;
    key_count_nxt = key_count_r;
    value_nxt     = value_r;
    hit_nxt       = hit_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    perm_we       = 1'b0;
    perm_waddr    = i_r;
    perm_wdata    = sj_r;
    perm_raddr    = ks_addr;
    key_we        = 1'b0;
    case (state_r)
      rc4_pkg::ST_INIT: begin
        // write identity, reset schedule indices
        perm_we    = 1'b1;
        perm_waddr = i_r;
        perm_wdata = i_r;
        i_nxt      = i_r + 8'd1;
        j_nxt      = 8'd0;
        kpos_nxt   = 8'd0;
      end
      rc4_pkg::ST_IDLE: begin
        in_tready  = 1'b1;
        perm_raddr = i_r + 8'd1;
        if (accept) begin
          value_nxt = in_tdata;
          if (in_tuser == rc4_pkg::MODE_DATA) begin
            i_nxt = i_r + 8'd1;
          end else begin
            // store key word unless the key store is full
            if (key_room) begin
              key_we        = 1'b1;
              key_count_nxt = key_count_r + CW'(1);
            end
            if (in_tlast) begin
              i_nxt = 8'd0;
              j_nxt = 8'd0;
            end
          end
        end
      end
      rc4_pkg::ST_D_J: begin
        si_nxt     = perm_rdata_r;
        j_nxt      = j_sum;
        perm_raddr = j_sum;
      end
      rc4_pkg::ST_D_WI: begin
        sj_nxt     = perm_rdata_r;
        perm_we    = 1'b1;
        perm_waddr = i_r;
        perm_wdata = perm_rdata_r;
      end
      rc4_pkg::ST_D_WJ: begin
        // a read of S[j] here would see the old value: bypass it
        perm_we    = 1'b1;
        perm_waddr = j_r;
        perm_wdata = si_r;
        perm_raddr = ks_addr;
        hit_nxt    = (ks_addr == j_r);
      end
      rc4_pkg::ST_D_KS: begin
        perm_raddr = ks_addr;
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = value_r ^ ks_byte;
        end
      end
      rc4_pkg::ST_K_RD: begin
        perm_raddr = i_r;
      end
      rc4_pkg::ST_K_J: begin
        si_nxt     = perm_rdata_r;
        j_nxt      = j_sum;
        perm_raddr = j_sum;
      end
      rc4_pkg::ST_K_WI: begin
        perm_we    = 1'b1;
        perm_waddr = i_r;
        perm_wdata = perm_rdata_r;
      end
      rc4_pkg::ST_K_WJ: begin
        perm_we    = 1'b1;
        perm_waddr = j_r;
        perm_wdata = si_r;
        i_nxt      = i_r + 8'd1;
        kpos_nxt   = (kpos_inc >= key_count_r) ? 8'd0 : kpos_inc[7:0];
        // end of schedule: clear indices and empty the key store
        if (i_r == 8'hFF) begin
          j_nxt         = 8'd0;
          key_count_nxt = '0;
        end
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // Permutation memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (perm_we) perm_mem[perm_waddr] <= perm_wdata;
    perm_rdata_r <= perm_mem[perm_raddr];
  end

  // Key memory: written on key words, read by the schedule
  always_ff @(posedge clk) begin
    if (key_we) key_mem[key_count_r[7:0]] <= in_tdata;
    key_rdata_r <= key_mem[kpos_r];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rc4_pkg::ST_INIT;
      i_r         <= 8'd0;
      j_r         <= 8'd0;
      kpos_r      <= 8'd0;
      key_count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      kpos_r      <= kpos_nxt;
      key_count_r <= key_count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    si_r       <= si_nxt;
    sj_r       <= sj_nxt;
    value_r    <= value_nxt;
    hit_r      <= hit_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

[rtl/rc4_checker.sv]
`default_nettype none

module rc4_sva_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tvalid,
  input wire logic       in_tready,
  input wire logic       in_tuser,
  input wire logic       in_tlast,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word dropped or changed while stalled");

  // A data word keeps the engine busy the next cycle
  a_data_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> !in_tready)
    else $error("ready right after a data word");

  // A key word without last leaves the input ready the next cycle
  a_key_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser && !in_tlast |=> in_tready)
    else $error("not ready after a plain key word");

  // A last key word starts the identity fill and then the schedule
  a_sched_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser && in_tlast |=> !in_tready)
    else $error("ready right after the last key word");

  // Reset empties the output and starts the identity fill
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("output valid or ready after reset");

endmodule

bind rc4_stream_cipher rc4_sva_checker u_rc4_sva_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
